/* hdl/isa_pkg.sv */
// Shared constants and binary32 rounding helper for the inverse square root pipeline.
package isa_pkg;

   localparam logic [31:0] SIGN_MASK   = 32'h8000_0000;
   localparam logic [31:0] MAG_MASK    = 32'h7fff_ffff;
   localparam logic [31:0] EXP_INF     = 32'h7f80_0000;
   localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
   localparam logic [31:0] DEFAULT_NAN = 32'hffc0_0000;
   localparam logic [31:0] MAGIC_GUESS = 32'h5f37_59df;
   localparam logic [31:0] F_HALF      = 32'h3f00_0000;
   localparam logic [31:0] F_THREEHALF = 32'h3fc0_0000;

   localparam int SIG_W = 57;   // widest significand handed to rounding
   localparam int EXP_W = 12;   // signed exponent, value = sig * 2^(e-150)

   function automatic logic fp_is_nan(input logic [31:0] v);
      return (v & MAG_MASK) > EXP_INF;
   endfunction

   function automatic logic fp_is_inf(input logic [31:0] v);
      return (v & MAG_MASK) == EXP_INF;
   endfunction

   // round sig * 2^(e-150) to binary32, nearest even; sig nonzero
   function automatic logic [31:0] fp_round(input logic sign,
                                            input logic [SIG_W-1:0] sig,
                                            input logic signed [EXP_W-1:0] e);
      logic [5:0] p;
      logic signed [EXP_W-1:0] lead;
      logic signed [EXP_W-1:0] lim;
      logic signed [EXP_W-1:0] sh;
      logic signed [EXP_W-1:0] be;
      logic [5:0] shc;
      logic [2*SIG_W-1:0] ext;
      logic [24:0] q;
      logic g;
      logic st;
      logic [31:0] r;
      p = 6'd0;
      for (int i = 0; i < SIG_W; i++) begin
         if (sig[i]) p = 6'(i);
      end
      lim  = 12'sd24 - e;
      lead = ($signed({6'd0, p}) > lim) ? $signed({6'd0, p}) : lim;
      sh   = lead - 12'sd23;
      be   = lead + e - 12'sd23;
      ext  = '0;
      if (sh <= 12'sd0) begin
         q  = 25'(sig[24:0] << 5'(-sh));
         g  = 1'b0;
         st = 1'b0;
      end else begin
         shc = (sh > 12'sd58) ? 6'd58 : 6'(sh);
         ext = {sig, {SIG_W{1'b0}}} >> shc;
         q   = 25'(ext[2*SIG_W-1:SIG_W]);
         g   = ext[SIG_W-1];
         st  = |ext[SIG_W-2:0];
      end
      q = q + 25'(g & (st | q[0]));
      if (q[24]) begin
         q  = q >> 1;
         be = be + 12'sd1;
      end
      if (q[23]) begin
         if (be >= 12'sd255) r = {sign, 8'hff, 23'd0};
         else r = {sign, be[7:0], q[22:0]};
      end else begin
         r = {sign, 8'd0, q[22:0]};
      end
      return r;
   endfunction

endpackage

/* hdl/isa_fmul.sv */
// Two-stage binary32 multiplier with a sideband word carried alongside.
module isa_fmul
   import isa_pkg::*;
#(
   parameter int SIDE_W = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [31:0]       in_a,
   input  logic [31:0]       in_b,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [31:0]       out_res,
   output logic [SIDE_W-1:0] out_side
);

   logic              va_ff, vb_ff;
   logic              spec_ff, spec_in;
   logic [31:0]       sval_ff, sval_in;
   logic              sign_ff, sign_in;
   logic [47:0]       prod_ff, prod_in;
   logic signed [EXP_W-1:0] e_ff, e_in;
   logic [SIDE_W-1:0] sa_ff, sb_ff;
   logic [31:0]       res_ff, res_in;

   logic [23:0] siga, sigb;
   logic [8:0]  ea, eb;

   always_comb begin
      sign_in = in_a[31] ^ in_b[31];
      siga    = {in_a[30:23] != 8'd0, in_a[22:0]};
      sigb    = {in_b[30:23] != 8'd0, in_b[22:0]};
      ea      = (in_a[30:23] == 8'd0) ? 9'd1 : {1'b0, in_a[30:23]};
      eb      = (in_b[30:23] == 8'd0) ? 9'd1 : {1'b0, in_b[30:23]};
      prod_in = siga * sigb;
      e_in    = $signed(EXP_W'(ea) + EXP_W'(eb)) - 12'sd150;
      spec_in = 1'b1;
      if (fp_is_nan(in_a)) sval_in = in_a | QUIET_BIT;
      else if (fp_is_nan(in_b)) sval_in = in_b | QUIET_BIT;
      else if (fp_is_inf(in_a) || fp_is_inf(in_b)) begin
         if ((in_a & MAG_MASK) == '0 || (in_b & MAG_MASK) == '0) sval_in = DEFAULT_NAN;
         else sval_in = {sign_in, 31'd0} | EXP_INF;
      end else if (siga == '0 || sigb == '0) sval_in = {sign_in, 31'd0};
      else begin
         spec_in = 1'b0;
         sval_in = '0;
      end
   end

   always_comb begin
      if (spec_ff) res_in = sval_ff;
      else res_in = fp_round(sign_ff, SIG_W'(prod_ff), e_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         spec_ff <= spec_in;
         sval_ff <= sval_in;
         sign_ff <= sign_in;
         prod_ff <= prod_in;
         e_ff    <= e_in;
         sa_ff   <= in_side;
         res_ff  <= res_in;
         sb_ff   <= sa_ff;
      end
   end

   assign out_valid = vb_ff;
   assign out_res   = res_ff;
   assign out_side  = sb_ff;

endmodule

/* hdl/isa_fsub.sv */
// Two-stage binary32 subtractor (a - b) with a sideband word carried alongside.
module isa_fsub
   import isa_pkg::*;
#(
   parameter int SIDE_W = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [31:0]       in_a,
   input  logic [31:0]       in_b,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [31:0]       out_res,
   output logic [SIDE_W-1:0] out_side
);

   logic              va_ff, vb_ff;
   logic              spec_ff, spec_in;
   logic [31:0]       sval_ff, sval_in;
   logic              sign_ff, sign_in;
   logic [SIG_W-1:0]  sum_ff, sum_in;
   logic signed [EXP_W-1:0] e_ff, e_in;
   logic [SIDE_W-1:0] sa_ff, sb_ff;
   logic [31:0]       res_ff, res_in;

   logic [31:0]      bn;
   logic [23:0]      siga, sigb;
   logic [8:0]       ea, eb;
   logic [23:0]      big_s, sml_s;
   logic [8:0]       big_e, sml_e, d;
   logic             big_sg, sml_sg;
   logic [SIG_W-1:0] big_al, sml_al;

   always_comb begin
      bn   = in_b ^ SIGN_MASK;
      siga = {in_a[30:23] != 8'd0, in_a[22:0]};
      sigb = {bn[30:23] != 8'd0, bn[22:0]};
      ea   = (in_a[30:23] == 8'd0) ? 9'd1 : {1'b0, in_a[30:23]};
      eb   = (bn[30:23] == 8'd0) ? 9'd1 : {1'b0, bn[30:23]};
      if (ea >= eb) begin
         big_s = siga; sml_s = sigb; big_e = ea; sml_e = eb;
         big_sg = in_a[31]; sml_sg = bn[31];
      end else begin
         big_s = sigb; sml_s = siga; big_e = eb; sml_e = ea;
         big_sg = bn[31]; sml_sg = in_a[31];
      end
      d = big_e - sml_e;
      // far apart: small operand only matters as a sticky bit
      if (d > 9'd32) begin
         big_al = SIG_W'(big_s) << 32;
         sml_al = SIG_W'(sml_s != '0);
         e_in   = $signed(EXP_W'(big_e)) - 12'sd32;
      end else begin
         big_al = SIG_W'(big_s) << d[5:0];
         sml_al = SIG_W'(sml_s);
         e_in   = $signed(EXP_W'(sml_e));
      end
      if (big_sg == sml_sg) begin
         sum_in  = big_al + sml_al;
         sign_in = big_sg;
      end else if (big_al >= sml_al) begin
         sum_in  = big_al - sml_al;
         sign_in = big_sg;
      end else begin
         sum_in  = sml_al - big_al;
         sign_in = sml_sg;
      end
      spec_in = 1'b1;
      if (fp_is_nan(in_a)) sval_in = in_a | QUIET_BIT;
      else if (fp_is_nan(in_b)) sval_in = in_b | QUIET_BIT;
      else if (fp_is_inf(in_a) && fp_is_inf(bn)) begin
         if (in_a[31] != bn[31]) sval_in = DEFAULT_NAN;
         else sval_in = in_a;
      end else if (fp_is_inf(in_a)) sval_in = in_a;
      else if (fp_is_inf(bn)) sval_in = bn;
      else if ((in_a & MAG_MASK) == '0 && (bn & MAG_MASK) == '0) sval_in = in_a & bn;
      else begin
         spec_in = 1'b0;
         sval_in = '0;
      end
   end

   always_comb begin
      if (spec_ff) res_in = sval_ff;
      else if (sum_ff == '0) res_in = '0;
      else res_in = fp_round(sign_ff, sum_ff, e_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         spec_ff <= spec_in;
         sval_ff <= sval_in;
         sign_ff <= sign_in;
         sum_ff  <= sum_in;
         e_ff    <= e_in;
         sa_ff   <= in_side;
         res_ff  <= res_in;
         sb_ff   <= sa_ff;
      end
   end

   assign out_valid = vb_ff;
   assign out_res   = res_ff;
   assign out_side  = sb_ff;

endmodule

/* hdl/inverse_sqrt_approx.sv */
// Top level: pipelined approximate reciprocal square root of binary32 values.
//
//  channel | dir | signals                      | payload
//  req     | in  | req_tvalid/tready/tdata     | x_bits[31:0]
//  rsp     | out | rsp_tvalid/tready/tdata     | result_bits[31:0]
//
// Five float units (h = x*0.5, t = h*y0, t = t*y0, s = 1.5 - t, r = y0*s),
// each split into an operate stage and a round stage. One transfer per cycle
// is sustained absent a stall; the seed y0 rides along as sideband.
// Whole pipeline advances when the output register is empty or being taken;
// req_tready follows that, so a stall holds every stage in place.
// Synchronous reset clears the valid bits only.
module inverse_sqrt_approx
   import isa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] x_bits
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] result_bits
);

   logic        en;
   logic [31:0] y0;
   logic        v1, v2, v3, v4;
   logic [31:0] h, t1, t2, s;
   logic [31:0] y1, y2, y3, y4;

   // global advance: last stage free or draining
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // magic seed, wraps mod 2^32
   assign y0 = MAGIC_GUESS - (req_tdata >> 1);

   isa_fmul #(.SIDE_W(32)) u_half (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(req_tvalid), .in_a(req_tdata), .in_b(F_HALF), .in_side(y0),
      .out_valid(v1), .out_res(h), .out_side(y1)
   );

   isa_fmul #(.SIDE_W(32)) u_hy (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v1), .in_a(h), .in_b(y1), .in_side(y1),
      .out_valid(v2), .out_res(t1), .out_side(y2)
   );

   isa_fmul #(.SIDE_W(32)) u_hyy (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v2), .in_a(t1), .in_b(y2), .in_side(y2),
      .out_valid(v3), .out_res(t2), .out_side(y3)
   );

   isa_fsub #(.SIDE_W(32)) u_sub (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v3), .in_a(F_THREEHALF), .in_b(t2), .in_side(y3),
      .out_valid(v4), .out_res(s), .out_side(y4)
   );

   // final product feeds the output register directly
   isa_fmul #(.SIDE_W(1)) u_out (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v4), .in_a(y4), .in_b(s), .in_side(1'b0),
      .out_valid(rsp_tvalid), .out_res(rsp_tdata), .out_side()
   );

endmodule

/* hdl/isa_checker.sv */
// Port-level checker for the inverse square root pipeline, bound to the top level.
module isa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // input side takes a transfer exactly when the output side can move
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready out of step with output");

   // with an empty output and no input transfer, all ten stages flush and no result appears
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid && !(req_tvalid && req_tready)) [*10] |=> !rsp_tvalid)
      else $error("result appeared without an input transfer");

endmodule

bind inverse_sqrt_approx isa_checker u_isa_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
